// File: rtl/mfd_pkg.sv
// Shared types and constants for the mux frame deframer.
`default_nettype none

package mfd_pkg;

	// default ring depth, in entries
	localparam int unsigned BUFFER_DEPTH_DEF = 512;

	// fixed field widths
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned ADDR_W   = 9;
	localparam int unsigned PORT_W   = 3;
	localparam int unsigned TDATA_W  = 40;
	localparam int unsigned TUSER_W  = 3;

	// framing characters
	localparam logic [BYTE_W-1:0] CH_START  = 8'h5F;
	localparam logic [BYTE_W-1:0] CH_OPEN   = 8'h28;
	localparam logic [BYTE_W-1:0] CH_CLOSE  = 8'h29;
	localparam logic [BYTE_W-1:0] CH_DIGIT0 = 8'h30;
	localparam logic [BYTE_W-1:0] CH_DIGIT4 = 8'h34;
	localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;

	// master tuser bit positions
	localparam int unsigned TU_STORE = 0;
	localparam int unsigned TU_DONE  = 1;
	localparam int unsigned TU_DROP  = 2;

	// parser phase
	typedef enum logic [2:0] {
		PH_HUNT    = 3'd0,
		PH_OPEN    = 3'd1,
		PH_PORT    = 3'd2,
		PH_LEN     = 3'd3,
		PH_CLOSE   = 3'd4,
		PH_START2  = 3'd5,
		PH_PAYLOAD = 3'd6
	} phase_t;

	// one result word, unpacked
	typedef struct packed {
		logic              store_valid;
		logic [ADDR_W-1:0] store_addr;
		logic [BYTE_W-1:0] store_data;
		logic              frame_done;
		logic [PORT_W-1:0] frame_port;
		logic [BYTE_W-1:0] frame_length;
		logic [ADDR_W-1:0] frame_start;
		logic              frame_dropped;
	} result_t;

endpackage

`default_nettype wire

// File: rtl/mux_frame_deframer_core.sv
// Mux frame deframer: frame parser with ring-buffer write output.
`default_nettype none
// Usage:
// Slave channel s_axis_* takes one received byte per word in tdata[7:0].
// The parser looks for '_' '(' port digit '0'..'4', nonzero length byte, ')' '_',
// then that many payload bytes and a CR. Every accepted byte yields exactly one
// master word on m_axis_*: tuser flags say whether it is a payload byte to store
// at store_addr in an external ring of BUFFER_DEPTH entries, a completed frame
// (port, length, start position), or a dropped frame (CR missing; the write
// position rewinds to the frame start). A word with no flag set is a no-op.
// Each accepted byte's result is registered in the output register; the block
// takes one byte per cycle, limited only by the single output register.
// s_axis_tready is high when the output register is empty or being drained, so
// a stalled receiver holds the result and stops input after one word.
// Reset (arst_n low, asynchronous) returns the parser to hunting, clears the
// write position, frame counters and the output valid.
// The ring position counter is clog2(BUFFER_DEPTH) bits wide; store_addr and
// frame_start carry its low 9 bits, zero-extended when the counter is narrower.

module mux_frame_deframer_core #(
	parameter int unsigned BUFFER_DEPTH = mfd_pkg::BUFFER_DEPTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_axis_tvalid,
	output logic                              s_axis_tready,
	// tdata: rx_byte[7:0]
	input  wire logic [mfd_pkg::BYTE_W-1:0]   s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  wire logic                         m_axis_tready,
	// tdata: store_addr[8:0], store_data[16:9], frame_port[19:17],
	//        frame_length[27:20], frame_start[36:28], zero pad[39:37]
	output logic [mfd_pkg::TDATA_W-1:0]       m_axis_tdata,
	// tuser: store_valid[0], frame_done[1], frame_dropped[2]
	output logic [mfd_pkg::TUSER_W-1:0]       m_axis_tuser
);

	localparam int unsigned PW    = $clog2(BUFFER_DEPTH);
	localparam int unsigned AW    = mfd_pkg::ADDR_W;
	localparam int unsigned BW    = mfd_pkg::BYTE_W;
	localparam int unsigned PAD_W = mfd_pkg::TDATA_W - (2 * AW + 2 * BW + mfd_pkg::PORT_W);
	localparam logic [PW-1:0] POS_LAST = PW'(BUFFER_DEPTH - 1);

	// parser state
	mfd_pkg::phase_t             phase_q, phase_d;
	logic [PW-1:0]               wpos_q, wpos_d;
	logic [PW-1:0]               start_q, start_d;
	logic [mfd_pkg::PORT_W-1:0]  port_q, port_d;
	logic [BW-1:0]               remain_q, remain_d;
	logic [BW-1:0]               stored_q, stored_d;

	// output register
	logic                        out_valid_q;
	mfd_pkg::result_t            res_q, res_d;

	logic                        in_fire;
	logic [BW-1:0]               rx;
	logic [PW-1:0]               wpos_next;
	logic [AW-1:0]               wpos_addr, start_addr;

	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign rx            = s_axis_tdata;

	// wrapping increment of the ring position
	assign wpos_next = (wpos_q == POS_LAST) ? '0 : wpos_q + PW'(1);

	// ring positions mapped onto the 9-bit address fields
	generate
		if (PW >= AW) begin : g_addr_trunc
			assign wpos_addr  = wpos_q[AW-1:0];
			assign start_addr = start_q[AW-1:0];
		end else begin : g_addr_ext
			assign wpos_addr  = {{(AW-PW){1'b0}}, wpos_q};
			assign start_addr = {{(AW-PW){1'b0}}, start_q};
		end
	endgenerate

	// next parser state
	always_comb begin
		phase_d  = phase_q;
		wpos_d   = wpos_q;
		start_d  = start_q;
		port_d   = port_q;
		remain_d = remain_q;
		stored_d = stored_q;
		unique case (phase_q)
			mfd_pkg::PH_HUNT: begin
				if (rx == mfd_pkg::CH_START) begin
					start_d = wpos_q;
					phase_d = mfd_pkg::PH_OPEN;
				end
			end
			mfd_pkg::PH_OPEN: begin
				phase_d = (rx == mfd_pkg::CH_OPEN) ? mfd_pkg::PH_PORT : mfd_pkg::PH_HUNT;
			end
			mfd_pkg::PH_PORT: begin
				if (rx >= mfd_pkg::CH_DIGIT0 && rx <= mfd_pkg::CH_DIGIT4) begin
					// '0'..'4' carry the port in their low three bits
					port_d  = rx[mfd_pkg::PORT_W-1:0];
					phase_d = mfd_pkg::PH_LEN;
				end else begin
					phase_d = mfd_pkg::PH_HUNT;
				end
			end
			mfd_pkg::PH_LEN: begin
				if (rx != '0) begin
					remain_d = rx;
					phase_d  = mfd_pkg::PH_CLOSE;
				end else begin
					phase_d = mfd_pkg::PH_HUNT;
				end
			end
			mfd_pkg::PH_CLOSE: begin
				phase_d = (rx == mfd_pkg::CH_CLOSE) ? mfd_pkg::PH_START2 : mfd_pkg::PH_HUNT;
			end
			mfd_pkg::PH_START2: begin
				phase_d = (rx == mfd_pkg::CH_START) ? mfd_pkg::PH_PAYLOAD : mfd_pkg::PH_HUNT;
			end
			mfd_pkg::PH_PAYLOAD: begin
				if (remain_q != '0) begin
					remain_d = remain_q - BW'(1);
					stored_d = stored_q + BW'(1);
					wpos_d   = wpos_next;
				end else begin
					// missing CR rewinds the ring to the frame start
					if (rx != mfd_pkg::CH_CR) begin
						wpos_d = start_q;
					end
					phase_d  = mfd_pkg::PH_HUNT;
					remain_d = '0;
					stored_d = '0;
				end
			end
			default: begin
				phase_d = mfd_pkg::PH_HUNT;
			end
		endcase
	end

	// result word for the current byte
	always_comb begin
		res_d = '0;
		if (phase_q == mfd_pkg::PH_PAYLOAD) begin
			if (remain_q != '0) begin
				res_d.store_valid = 1'b1;
				res_d.store_addr  = wpos_addr;
				res_d.store_data  = rx;
			end else if (rx == mfd_pkg::CH_CR) begin
				res_d.frame_done   = 1'b1;
				res_d.frame_port   = port_q;
				res_d.frame_length = stored_q;
				res_d.frame_start  = start_addr;
			end else begin
				res_d.frame_dropped = 1'b1;
			end
		end
	end

	// parser state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= mfd_pkg::PH_HUNT;
			wpos_q   <= '0;
			start_q  <= '0;
			port_q   <= '0;
			remain_q <= '0;
			stored_q <= '0;
		end else if (in_fire) begin
			phase_q  <= phase_d;
			wpos_q   <= wpos_d;
			start_q  <= start_d;
			port_q   <= port_d;
			remain_q <= remain_d;
			stored_q <= stored_d;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			res_q <= res_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{PAD_W{1'b0}}, res_q.frame_start, res_q.frame_length,
		res_q.frame_port, res_q.store_data, res_q.store_addr};
	assign m_axis_tuser  = {res_q.frame_dropped, res_q.frame_done, res_q.store_valid};

endmodule

`default_nettype wire

// File: rtl/mfd_checker.sv
// Port-level checker for the mux frame deframer, bound to the top level.
`default_nettype none

module mfd_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        s_axis_tvalid,
	input wire logic                        s_axis_tready,
	input wire logic [mfd_pkg::BYTE_W-1:0]  s_axis_tdata,
	input wire logic                        m_axis_tvalid,
	input wire logic                        m_axis_tready,
	input wire logic [mfd_pkg::TDATA_W-1:0] m_axis_tdata,
	input wire logic [mfd_pkg::TUSER_W-1:0] m_axis_tuser
);

	// a stalled result word is held
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled result word changed");

	// input is refused only while a result waits on a stalled receiver
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without output backpressure");

	// every accepted byte shows up as a result word on the next cycle
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
		else $error("accepted byte produced no result word");

	// a word is a store, a completed frame, a drop, or nothing
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> $onehot0(m_axis_tuser))
		else $error("more than one result flag set");

	// store fields are zero unless a payload byte is stored
	a_store_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[mfd_pkg::TU_STORE] |-> m_axis_tdata[16:0] == '0)
		else $error("store fields set without store flag");

endmodule

bind mux_frame_deframer_core mfd_checker u_mfd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// File: test/mfd_checker.sv
// Checker for the mux frame deframer: watches both channels, predicts each result word and compares.
`default_nettype none

module mfd_scoreboard
	import mfd_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	input  wire logic               s_tready,
	// tdata: rx_byte[7:0]
	input  wire logic [BYTE_W-1:0]  s_tdata,
	input  wire logic               m_tvalid,
	input  wire logic               m_tready,
	// tdata: store_addr[8:0], store_data[16:9], frame_port[19:17],
	//        frame_length[27:20], frame_start[36:28], zero pad[39:37]
	input  wire logic [TDATA_W-1:0] m_tdata,
	// tuser: store_valid[0], frame_done[1], frame_dropped[2]
	input  wire logic [TUSER_W-1:0] m_tuser,
	output int                      fail_count,
	output int                      words_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RING_DEPTH = BUFFER_DEPTH_DEF;

	// parser state as the block should hold it
	phase_t            ph;
	logic [ADDR_W-1:0] wr_pos;
	logic [ADDR_W-1:0] frame_base;
	logic [PORT_W-1:0] port_sel;
	logic [BYTE_W-1:0] left;
	logic [BYTE_W-1:0] stored;

	result_t expected_q[$];
	int      mismatches = 0;

	initial begin
		fail_count = 0;
		words_pending = 0;
	end

	// advance the parser by one received byte and build the result word it yields
	function automatic result_t deframe_byte(input logic [BYTE_W-1:0] b);
		result_t r;
		r = '0;
		case (ph)
			PH_HUNT: begin
				if (b == CH_START) begin
					frame_base = wr_pos;
					ph = PH_OPEN;
				end
			end
			PH_OPEN: ph = (b == CH_OPEN) ? PH_PORT : PH_HUNT;
			PH_PORT: begin
				// only '0'..'4' name a port
				if (b >= CH_DIGIT0 && b <= CH_DIGIT4) begin
					port_sel = PORT_W'(b - CH_DIGIT0);
					ph = PH_LEN;
				end else begin
					ph = PH_HUNT;
				end
			end
			PH_LEN: begin
				if (b != '0) begin
					left = b;
					ph = PH_CLOSE;
				end else begin
					ph = PH_HUNT;
				end
			end
			PH_CLOSE: ph = (b == CH_CLOSE) ? PH_START2 : PH_HUNT;
			PH_START2: ph = (b == CH_START) ? PH_PAYLOAD : PH_HUNT;
			PH_PAYLOAD: begin
				if (left != '0) begin
					r.store_valid = 1'b1;
					r.store_addr = wr_pos;
					r.store_data = b;
					left = left - 1'b1;
					stored = stored + 1'b1;
					wr_pos = (wr_pos == ADDR_W'(RING_DEPTH - 1)) ? '0 : wr_pos + 1'b1;
				end else begin
					if (b == CH_CR) begin
						r.frame_done = 1'b1;
						r.frame_port = port_sel;
						r.frame_length = stored;
						r.frame_start = frame_base;
					end else begin
						// missing CR: drop the frame and rewind the ring
						r.frame_dropped = 1'b1;
						wr_pos = frame_base;
					end
					ph = PH_HUNT;
					left = '0;
					stored = '0;
				end
			end
			default: ph = PH_HUNT;
		endcase
		return r;
	endfunction

	task automatic check_field(input string name, input int unsigned exp_v,
			input int unsigned act_v);
		if (exp_v != act_v) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
			mismatches++;
		end
	endtask

	// compare one output word with the oldest expectation
	task automatic compare_word(input result_t exp_w, input logic [TDATA_W-1:0] data,
			input logic [TUSER_W-1:0] user);
		check_field("store_valid", exp_w.store_valid, user[TU_STORE]);
		check_field("frame_done", exp_w.frame_done, user[TU_DONE]);
		check_field("frame_dropped", exp_w.frame_dropped, user[TU_DROP]);
		check_field("store_addr", exp_w.store_addr, data[8:0]);
		check_field("store_data", exp_w.store_data, data[16:9]);
		check_field("frame_port", exp_w.frame_port, data[19:17]);
		check_field("frame_length", exp_w.frame_length, data[27:20]);
		check_field("frame_start", exp_w.frame_start, data[36:28]);
		check_field("tdata pad", 0, data[39:37]);
	endtask

	// sample both channels at the rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph = PH_HUNT;
			wr_pos = '0;
			frame_base = '0;
			port_sel = '0;
			left = '0;
			stored = '0;
			expected_q.delete();
		end else begin
			if (s_tvalid && s_tready)
				expected_q.push_back(deframe_byte(s_tdata));
			if (m_tvalid && m_tready) begin
				if (expected_q.size() == 0) begin
					$error("result word with nothing expected: tuser 0x%0h tdata 0x%0h",
						m_tuser, m_tdata);
					mismatches++;
				end else begin
					compare_word(expected_q.pop_front(), m_tdata, m_tuser);
				end
			end
		end
		fail_count <= mismatches;
		words_pending <= expected_q.size();
	end

endmodule

`default_nettype wire

// File: test/tb_mux_frame_deframer_core.sv
// Testbench top for the mux frame deframer: reset, byte stimulus, handshake pressure and verdict.
`default_nettype none

module tb_mux_frame_deframer_core;
	timeunit 1ns;
	timeprecision 1ps;

	import mfd_pkg::*;

	localparam int IDLE_LIMIT = 5000;
	localparam int PHASES = 5;
	localparam int PHASE_BYTES = 75;
	// percent of cycles the sender idles / the receiver stalls, per phase
	localparam int SRC_IDLE[PHASES]  = '{0, 83, 0, 38, 0};
	localparam int DST_STALL[PHASES] = '{0, 0, 83, 38, 0};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_axis_tvalid = 1'b0;
	wire logic          s_axis_tready;
	logic [BYTE_W-1:0]  s_axis_tdata = '0;
	wire logic          m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	wire [TDATA_W-1:0]  m_axis_tdata;
	wire [TUSER_W-1:0]  m_axis_tuser;

	int fail_count;
	int words_pending;
	int src_idle = 0;
	int dst_stall = 0;
	int sent = 0;
	int idle_cycles = 0;

	// header checks, a bad port digit on each side, zero length, drop and rewind
	localparam logic [BYTE_W-1:0] DIRECTED[27] = '{
		CH_START, CH_OPEN, CH_DIGIT4, 8'h01, CH_CLOSE, CH_START, 8'hFF, CH_CR,
		CH_START, CH_OPEN, CH_DIGIT0, 8'h02, CH_CLOSE, CH_START, 8'h00, 8'h80, 8'h55,
		CH_START, CH_OPEN, 8'h2F,
		CH_START, CH_OPEN, 8'h35,
		CH_START, CH_OPEN, 8'h31, 8'h00
	};

	always #1 clk = ~clk;

	mux_frame_deframer_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	mfd_scoreboard u_scoreboard (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_axis_tvalid),
		.s_tready      (s_axis_tready),
		.s_tdata       (s_axis_tdata),
		.m_tvalid      (m_axis_tvalid),
		.m_tready      (m_axis_tready),
		.m_tdata       (m_axis_tdata),
		.m_tuser       (m_axis_tuser),
		.fail_count    (fail_count),
		.words_pending (words_pending)
	);

	// receiver backpressure
	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= dst_stall);
	end

	// watchdog: too long without any word moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb: failure");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// present one byte, starting and ending at a falling edge
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		while ($urandom_range(99) < src_idle) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
		sent++;
	endtask

	task automatic send_frame(input int unsigned port, input int unsigned len,
			input logic [BYTE_W-1:0] term);
		send_byte(CH_START);
		send_byte(CH_OPEN);
		send_byte(CH_DIGIT0 + BYTE_W'(port));
		send_byte(BYTE_W'(len));
		send_byte(CH_CLOSE);
		send_byte(CH_START);
		repeat (len) send_byte(BYTE_W'($urandom_range(255)));
		send_byte(term);
	endtask

	// mostly whole frames; some cut-off headers and some line noise
	task automatic send_random_seq();
		int unsigned pick;
		int unsigned cut;
		int unsigned len;
		logic [BYTE_W-1:0] hdr[6];
		pick = $urandom_range(99);
		if (pick < 70) begin
			len = ($urandom_range(49) == 0) ? $urandom_range(255, 1) : $urandom_range(10, 1);
			send_frame($urandom_range(4), len,
				($urandom_range(4) == 0) ? BYTE_W'($urandom_range(255)) : CH_CR);
		end else if (pick < 90) begin
			hdr[0] = CH_START;
			hdr[1] = CH_OPEN;
			hdr[2] = CH_DIGIT0 + BYTE_W'($urandom_range(4));
			hdr[3] = BYTE_W'($urandom_range(255, 1));
			hdr[4] = CH_CLOSE;
			hdr[5] = CH_START;
			cut = $urandom_range(5);
			// corrupt one header byte, biased toward the port digit edges and zero
			case ($urandom_range(2))
				0: hdr[cut] = BYTE_W'($urandom_range(255));
				1: hdr[cut] = BYTE_W'($urandom_range(8'h38, 8'h2C));
				default: hdr[cut] = '0;
			endcase
			for (int i = 0; i <= cut; i++) send_byte(hdr[i]);
		end else begin
			repeat ($urandom_range(4, 1)) send_byte(BYTE_W'($urandom_range(255)));
		end
	endtask

	initial begin
		int target;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (DIRECTED[i]) send_byte(DIRECTED[i]);

		for (int p = 0; p < PHASES; p++) begin
			src_idle = SRC_IDLE[p];
			dst_stall = DST_STALL[p];
			target = sent + PHASE_BYTES;
			while (sent < target) send_random_seq();
		end
		s_axis_tvalid <= 1'b0;
		dst_stall = 0;

		// drain, then allow for the output register
		while (words_pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

`default_nettype wire
